>>> rtl/vpw_pkg.sv
// Shared constants, types and register indexes for the pulse-width frame receiver.
package vpw_pkg;

   // Frame buffer geometry
   localparam int FRAME_BYTES   = 12;
   localparam int BITS_PER_BYTE = 8;
   localparam int BUF_IDX_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int POS_W         = $clog2(FRAME_BYTES + 1);
   localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
   localparam int BYTE_INDEX_W  = 4;

   // Event queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOF_MIN   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOF_MAX   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_MIN = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_MAX = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MIN  = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MAX  = 8'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_EOF_MIN   = 8'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_WRAP = 8'd7;

   // Timing windows and timer wrap value
   typedef struct packed {
      logic [15:0] sof_min_us;
      logic [15:0] sof_max_us;
      logic [15:0] short_min_us;
      logic [15:0] short_max_us;
      logic [15:0] long_min_us;
      logic [15:0] long_max_us;
      logic [15:0] eof_min_us;
      logic [31:0] timer_wrap_us;
   } cfg_type;

   // Classified line events passed from the front to the back
   typedef enum logic [1:0] {
      EV_SOF,
      EV_BIT,
      EV_EOF,
      EV_RESYNC
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic        one;
   } event_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIFF,
      FRONT_WRAP,
      FRONT_CLASS
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DRAIN
   } back_state_type;

endpackage

>>> rtl/vpw_front.sv
// Front end: measures pulse widths, tracks frame state and classifies each edge.
module vpw_front (
   input  logic                clock,
   input  logic                reset,
   input  vpw_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [31:0]         req_edge_time_us,
   input  logic                req_level_before,
   output logic                ev_valid,
   input  logic                ev_ready,
   output vpw_pkg::event_type  ev_data
);
   import vpw_pkg::*;

   front_state_type state_ff, state_in;
   logic        active_ff, active_in;
   logic [31:0] prev_ff, prev_in;
   logic        cmd_ff, cmd_in;
   logic        high_ff, high_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] diff_ff, diff_in;
   logic        wrapped_ff, wrapped_in;
   logic [31:0] width_ff, width_in;

   logic in_sof, in_short, in_long, past_eof;

   // Window compares on the registered width
   always_comb begin
      in_sof   = (width_ff >= {16'd0, cfg.sof_min_us})   && (width_ff <= {16'd0, cfg.sof_max_us});
      in_short = (width_ff >= {16'd0, cfg.short_min_us}) &&
                 (width_ff <= {16'd0, cfg.short_max_us});
      in_long  = (width_ff >= {16'd0, cfg.long_min_us})  && (width_ff <= {16'd0, cfg.long_max_us});
      past_eof = width_ff > {16'd0, cfg.eof_min_us};
   end

   // Next state, datapath and event output
   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      prev_in    = prev_ff;
      cmd_in     = cmd_ff;
      high_in    = high_ff;
      now_in     = now_ff;
      diff_in    = diff_ff;
      wrapped_in = wrapped_ff;
      width_in   = width_ff;
      req_ready  = 1'b0;
      ev_valid   = 1'b0;
      ev_data    = '{kind: EV_BIT, one: 1'b0};
      case (state_ff)
         FRONT_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_cmd;
               now_in   = req_edge_time_us;
               high_in  = req_level_before;
               state_in = FRONT_DIFF;
            end
         end
         FRONT_DIFF: begin
            diff_in    = now_ff - prev_ff;
            wrapped_in = now_ff < prev_ff;
            prev_in    = now_ff;
            state_in   = FRONT_WRAP;
         end
         FRONT_WRAP: begin
            width_in = wrapped_ff ? (diff_ff + cfg.timer_wrap_us) : diff_ff;
            state_in = FRONT_CLASS;
         end
         FRONT_CLASS: begin
            if (cmd_ff) begin
               ev_valid = 1'b1;
               ev_data  = '{kind: EV_RESYNC, one: 1'b0};
               if (ev_ready) begin
                  active_in = 1'b0;
                  state_in  = FRONT_IDLE;
               end
            end else if (!active_ff) begin
               // Open a frame on a low pulse in the start window, drop anything else
               if (!high_ff && in_sof) begin
                  ev_valid = 1'b1;
                  ev_data  = '{kind: EV_SOF, one: 1'b0};
                  if (ev_ready) begin
                     active_in = 1'b1;
                     state_in  = FRONT_IDLE;
                  end
               end else begin
                  state_in = FRONT_IDLE;
               end
            end else if (high_ff && past_eof) begin
               ev_valid = 1'b1;
               ev_data  = '{kind: EV_EOF, one: 1'b0};
               if (ev_ready) begin
                  active_in = 1'b0;
                  state_in  = FRONT_IDLE;
               end
            end else begin
               ev_valid = 1'b1;
               ev_data  = '{kind: EV_BIT, one: high_ff ? in_long : in_short};
               if (ev_ready) begin
                  state_in = FRONT_IDLE;
               end
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FRONT_IDLE;
         active_ff <= 1'b0;
         prev_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         prev_ff   <= prev_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      high_ff    <= high_in;
      now_ff     <= now_in;
      diff_ff    <= diff_in;
      wrapped_ff <= wrapped_in;
      width_ff   <= width_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (ev_valid && ev_data.kind == EV_BIT) |-> active_ff)
      else $error("bit event raised outside a frame");

endmodule

>>> rtl/vpw_event_queue.sv
// Short queue of classified events between the front and back ends.
module vpw_event_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  vpw_pkg::event_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output vpw_pkg::event_type  pop_data
);
   import vpw_pkg::*;

   event_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   // Pointer and occupancy update
   always_comb begin
      push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = entries_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed event
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("event queue occupancy beyond depth");

endmodule

>>> rtl/vpw_back.sv
// Back end: packs bits into the frame buffer and drains it at end of frame.
module vpw_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ev_valid,
   output logic                ev_ready,
   input  vpw_pkg::event_type  ev_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_frame_byte,
   output logic [vpw_pkg::BYTE_INDEX_W-1:0] rsp_byte_index,
   output logic                rsp_last_byte
);
   import vpw_pkg::*;

   back_state_type          state_ff, state_in;
   logic [7:0]              cur_ff, cur_in;
   logic                    live_ff, live_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [BUF_IDX_W-1:0]    drain_idx_ff, drain_idx_in;
   logic [7:0]              buf_ff [FRAME_BYTES];
   logic [FRAME_BYTES-1:0]  buf_valid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff;
   logic [BYTE_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    wr_en;
   logic [BUF_IDX_W-1:0]    wr_idx;
   logic [7:0]              wr_data;
   logic                    clr_en;
   logic [7:0]              shifted;
   logic [POS_W-1:0]        pos_next;
   logic                    load_rsp;
   logic                    drain_last;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_last_byte  = rsp_last_ff;

   // Event handling and drain sequencing
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      live_in      = live_ff;
      pos_in       = pos_ff;
      bit_cnt_in   = bit_cnt_ff;
      drain_idx_in = drain_idx_ff;
      ev_ready     = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = pos_ff[BUF_IDX_W-1:0];
      wr_data      = cur_ff;
      clr_en       = 1'b0;
      load_rsp     = 1'b0;
      shifted      = {cur_ff[6:0], ev_data.one};
      pos_next     = pos_ff + 1'b1;
      drain_last   = drain_idx_ff == BUF_IDX_W'(FRAME_BYTES - 1);
      case (state_ff)
         BACK_IDLE: begin
            ev_ready = 1'b1;
            if (ev_valid) begin
               case (ev_data.kind)
                  EV_SOF: begin
                     cur_in     = '0;
                     live_in    = 1'b1;
                     pos_in     = '0;
                     bit_cnt_in = '0;
                  end
                  EV_RESYNC: begin
                     // Commit the partial byte so the buffer matches what was shifted in
                     wr_en      = live_ff;
                     live_in    = 1'b0;
                     pos_in     = '0;
                     bit_cnt_in = '0;
                  end
                  EV_BIT: begin
                     bit_cnt_in = bit_cnt_ff + 1'b1;
                     if (live_ff) begin
                        if (bit_cnt_in == '0) begin
                           wr_en   = 1'b1;
                           wr_data = shifted;
                           pos_in  = pos_next;
                           cur_in  = '0;
                           live_in = pos_next < POS_W'(FRAME_BYTES);
                        end else begin
                           cur_in = shifted;
                        end
                     end
                  end
                  EV_EOF: begin
                     // Append a zero bit to the open byte, then drain the whole buffer
                     wr_en        = live_ff;
                     wr_data      = {cur_ff[6:0], 1'b0};
                     live_in      = 1'b0;
                     bit_cnt_in   = bit_cnt_ff + 1'b1;
                     drain_idx_in = '0;
                     state_in     = BACK_DRAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BACK_DRAIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               clr_en   = 1'b1;
               if (drain_last) begin
                  state_in = BACK_IDLE;
               end else begin
                  drain_idx_in = drain_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Output register: load a drained byte, release it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = BYTE_INDEX_W'(drain_idx_ff);
         rsp_last_in  = drain_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         live_ff      <= 1'b0;
         pos_ff       <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         buf_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         pos_ff       <= pos_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            buf_valid_ff[wr_idx] <= 1'b1;
         end
         if (clr_en) begin
            buf_valid_ff[drain_idx_ff] <= 1'b0;
         end
      end
   end

   // Payload registers and buffer storage
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      drain_idx_ff <= drain_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      if (wr_en) begin
         buf_ff[wr_idx] <= wr_data;
      end
      // Read the drained byte, zero where the entry has not been written since reset or its last drain
      if (load_rsp) begin
         rsp_byte_ff <= buf_valid_ff[drain_idx_ff] ? buf_ff[drain_idx_ff] : 8'd0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == BYTE_INDEX_W'(FRAME_BYTES - 1)))
      else $error("last byte flagged away from the end of the buffer");

   assert property (@(posedge clock) disable iff (reset)
      live_ff |-> (pos_ff < POS_W'(FRAME_BYTES)))
      else $error("open byte beyond the frame buffer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_DRAIN) |-> !live_ff)
      else $error("open byte held while draining");

endmodule

>>> rtl/vpw_pulse_width_frame_receiver.sv
// Top level: configuration registers and the front, queue and back ends of the receiver.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid/ready, cmd, time, level   | in
//   result  | rsp_valid/ready, byte, index, last  | out
//   csr     | csr_valid/ready, csr_index, wdata   | in
//
// Each request passes through four front-end steps (accept, difference, wrap
// correction, classify), and a new request is taken only once it is classified.
// An end of frame drains FRAME_BYTES results from the buffer, one a cycle while
// rsp_ready takes them; the event queue lets further requests be classified meanwhile.
// Reset (synchronous) restores the default windows and clears the buffer;
// a stalled result holds in its output register and backs up the queue.
module vpw_pulse_width_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_edge_time_us,
   input  logic        req_level_before,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic [vpw_pkg::BYTE_INDEX_W-1:0] rsp_byte_index,
   output logic        rsp_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [vpw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import vpw_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      fe_valid, fe_ready;
   event_type fe_data;
   logic      be_valid, be_ready;
   event_type be_data;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SOF_MIN:    cfg_in.sof_min_us    = csr_wdata[15:0];
            CSR_SOF_MAX:    cfg_in.sof_max_us    = csr_wdata[15:0];
            CSR_SHORT_MIN:  cfg_in.short_min_us  = csr_wdata[15:0];
            CSR_SHORT_MAX:  cfg_in.short_max_us  = csr_wdata[15:0];
            CSR_LONG_MIN:   cfg_in.long_min_us   = csr_wdata[15:0];
            CSR_LONG_MAX:   cfg_in.long_max_us   = csr_wdata[15:0];
            CSR_EOF_MIN:    cfg_in.eof_min_us    = csr_wdata[15:0];
            CSR_TIMER_WRAP: cfg_in.timer_wrap_us = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sof_min_us    <= 16'd163;
         cfg_ff.sof_max_us    <= 16'd239;
         cfg_ff.short_min_us  <= 16'd34;
         cfg_ff.short_max_us  <= 16'd96;
         cfg_ff.long_min_us   <= 16'd97;
         cfg_ff.long_max_us   <= 16'd163;
         cfg_ff.eof_min_us    <= 16'd239;
         cfg_ff.timer_wrap_us <= 32'hFFFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vpw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_edge_time_us (req_edge_time_us),
      .req_level_before (req_level_before),
      .ev_valid         (fe_valid),
      .ev_ready         (fe_ready),
      .ev_data          (fe_data)
   );

   vpw_event_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (fe_ready),
      .push_data  (fe_data),
      .pop_valid  (be_valid),
      .pop_ready  (be_ready),
      .pop_data   (be_data)
   );

   vpw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .ev_valid       (be_valid),
      .ev_ready       (be_ready),
      .ev_data        (be_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

>>> sim/vpw_pulse_width_frame_receiver_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pulse-width frame receiver: directed edges, then random frames.
module vpw_pulse_width_frame_receiver_tb;
   import vpw_pkg::*;

   localparam logic CMD_EDGE       = 1'b0;
   localparam logic CMD_RESYNC     = 1'b1;
   localparam logic LINE_LOW       = 1'b0;
   localparam logic LINE_HIGH      = 1'b1;
   localparam int   SETTLE_CYCLES  = 40;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   ITEMS_PER_PHASE = 40;
   localparam int   PHASES         = 5;
   localparam int   DIRECTED_ROWS  = 24;

   // One directed edge; typed rows carry the byte 0 of the frame they close
   typedef struct packed {
      logic        cmd;
      logic [31:0] stamp;
      logic        level;
      logic        typed;
      logic [7:0]  byte0;
   } edge_row_type;

   localparam edge_row_type DIRECTED_EDGES [DIRECTED_ROWS] = '{
      // start of frame straight after reset, closed at once: all-zero frame
      '{CMD_EDGE,   32'd200,        LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd440,        LINE_HIGH, 1'b1, 8'h00},
      // stray high pulse outside a frame
      '{CMD_EDGE,   32'd490,        LINE_HIGH, 1'b0, 8'h00},
      // start at the window minimum, then every symbol at its window edges
      '{CMD_EDGE,   32'd653,        LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd750,        LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd784,        LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd947,        LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd1043,       LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd1139,       LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd1236,       LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd1269,       LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd1469,       LINE_LOW,  1'b0, 8'h00},
      // high pulse exactly at the end-of-frame limit is still a bit
      '{CMD_EDGE,   32'd1708,       LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd1948,       LINE_HIGH, 1'b1, 8'hF0},
      // resync near the top of the timer, start of frame across the wrap
      '{CMD_RESYNC, 32'hFFFF_FFA0,  LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd105,        LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd205,        LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'hFFFF_FFFF,  LINE_HIGH, 1'b1, 8'h02},
      // resync at time zero, start at the window maximum, resync mid-frame
      '{CMD_RESYNC, 32'd0,          LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd239,        LINE_LOW,  1'b0, 8'h00},
      '{CMD_EDGE,   32'd240,        LINE_LOW,  1'b0, 8'h00},
      '{CMD_RESYNC, 32'd300,        LINE_HIGH, 1'b0, 8'h00},
      // frame left: neither of these may close or open anything
      '{CMD_EDGE,   32'd541,        LINE_HIGH, 1'b0, 8'h00},
      '{CMD_EDGE,   32'd701,        LINE_LOW,  1'b0, 8'h00}
   };

   typedef struct {
      logic [7:0]              data;
      logic [BYTE_INDEX_W-1:0] pos;
      logic                    last;
   } rx_byte_type;

   logic                    clock;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic                    req_cmd          = CMD_EDGE;
   logic [31:0]             req_edge_time_us = '0;
   logic                    req_level_before = LINE_LOW;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic [7:0]              rsp_frame_byte;
   logic [BYTE_INDEX_W-1:0] rsp_byte_index;
   logic                    rsp_last_byte;
   logic                    csr_valid        = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index        = '0;
   logic [31:0]             csr_wdata        = '0;

   // Frame decoder mirror
   cfg_type     window_cfg;
   logic [31:0] last_edge_us;
   logic        in_frame;
   logic [2:0]  bits_in_byte;
   int          byte_pos;
   logic [7:0]  rx_buffer [FRAME_BYTES];
   logic [7:0]  frame_out [FRAME_BYTES];
   rx_byte_type bytes_due [$];

   // Stimulus and bookkeeping
   logic [31:0] cur_stamp     = '0;
   int          burst_left    = 0;
   bit          idle_free     = 1'b0;
   logic        stall_free    = 1'b0;
   int          frame_items   = 0;
   int          sent_count    = 0;
   int          frames_seen   = 0;
   int          checked_count = 0;
   int          fail_count    = 0;
   int          quiet_cycles  = 0;
   logic [12:0] ready_pattern = '0;
   int          pattern_step  = 0;

   vpw_pulse_width_frame_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_edge_time_us (req_edge_time_us),
      .req_level_before (req_level_before),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic cfg_type make_windows(input logic [15:0] sof_lo, input logic [15:0] sof_hi,
                                            input logic [15:0] short_lo, input logic [15:0] short_hi,
                                            input logic [15:0] long_lo, input logic [15:0] long_hi,
                                            input logic [15:0] eof_lo, input logic [31:0] wrap);
      cfg_type w;
      w.sof_min_us    = sof_lo;
      w.sof_max_us    = sof_hi;
      w.short_min_us  = short_lo;
      w.short_max_us  = short_hi;
      w.long_min_us   = long_lo;
      w.long_max_us   = long_hi;
      w.eof_min_us    = eof_lo;
      w.timer_wrap_us = wrap;
      return w;
   endfunction

   // Return to the power-on state of the decoder
   function automatic void reset_decoder();
      int k;
      window_cfg   = make_windows(16'd163, 16'd239, 16'd34, 16'd96, 16'd97, 16'd163, 16'd239,
                                  32'hFFFF_FFFF);
      last_edge_us = '0;
      in_frame     = 1'b0;
      bits_in_byte = '0;
      byte_pos     = 0;
      for (k = 0; k < FRAME_BYTES; k++) rx_buffer[k] = 8'h00;
   endfunction

   function automatic bit in_range(input logic [31:0] width, input logic [15:0] lo,
                                   input logic [15:0] hi);
      return width >= {16'h0, lo} && width <= {16'h0, hi};
   endfunction

   // Advance the decoder by one request; high when a whole frame is ready in frame_out
   function automatic bit decode_edge(input logic cmd_bit, input logic [31:0] now,
                                      input logic high);
      logic [31:0] width;
      bit          one;
      int          k;
      if (cmd_bit == CMD_RESYNC) begin
         bits_in_byte = '0;
         byte_pos     = 0;
         in_frame     = 1'b0;
         last_edge_us = now;
         return 1'b0;
      end
      // pulse width, corrected when the timer has wrapped
      if (now < last_edge_us)
         width = now + (window_cfg.timer_wrap_us - last_edge_us);
      else
         width = now - last_edge_us;
      last_edge_us = now;

      if (!in_frame) begin
         if (high == LINE_LOW && in_range(width, window_cfg.sof_min_us, window_cfg.sof_max_us)) begin
            in_frame     = 1'b1;
            bits_in_byte = '0;
            byte_pos     = 0;
            rx_buffer[0] = 8'h00;
         end
         return 1'b0;
      end

      if (byte_pos < FRAME_BYTES) rx_buffer[byte_pos] = rx_buffer[byte_pos] << 1;
      bits_in_byte = bits_in_byte + 3'd1;

      // long high pulse: hand over the whole buffer and clear it
      if (high == LINE_HIGH && width > {16'h0, window_cfg.eof_min_us}) begin
         for (k = 0; k < FRAME_BYTES; k++) begin
            frame_out[k] = rx_buffer[k];
            rx_buffer[k] = 8'h00;
         end
         in_frame = 1'b0;
         frames_seen++;
         return 1'b1;
      end

      if (high == LINE_HIGH)
         one = in_range(width, window_cfg.long_min_us, window_cfg.long_max_us);
      else
         one = in_range(width, window_cfg.short_min_us, window_cfg.short_max_us);
      if (one && byte_pos < FRAME_BYTES) rx_buffer[byte_pos][0] = 1'b1;

      // byte complete: move on, dropping anything past the buffer
      if (bits_in_byte == 3'd0) begin
         if (byte_pos < FRAME_BYTES) byte_pos++;
         if (byte_pos < FRAME_BYTES) rx_buffer[byte_pos] = 8'h00;
      end
      return 1'b0;
   endfunction

   // Offer one request in bursts with random gaps, then record what it should produce
   task automatic send_request(input logic cmd_bit, input logic [31:0] stamp, input logic level,
                               input bit typed, input logic [7:0] typed_b0);
      int          gap;
      int          k;
      rx_byte_type due;
      if (burst_left == 0) begin
         gap        = idle_free ? 0 : $urandom_range(14, 0);
         burst_left = $urandom_range(12, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_cmd          <= cmd_bit;
      req_edge_time_us <= stamp;
      req_level_before <= level;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      frame_items++;
      if (decode_edge(cmd_bit, stamp, level)) begin
         for (k = 0; k < FRAME_BYTES; k++) begin
            if (typed)
               due.data = (k == 0) ? typed_b0 : 8'h00;
            else
               due.data = frame_out[k];
            due.pos  = k[BYTE_INDEX_W-1:0];
            due.last = (k == FRAME_BYTES - 1);
            bytes_due.push_back(due);
         end
      end
   endtask

   // Hold the sender until every frame byte owed has come out
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_due.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (reg_index)
         CSR_SOF_MIN:    window_cfg.sof_min_us    = data[15:0];
         CSR_SOF_MAX:    window_cfg.sof_max_us    = data[15:0];
         CSR_SHORT_MIN:  window_cfg.short_min_us  = data[15:0];
         CSR_SHORT_MAX:  window_cfg.short_max_us  = data[15:0];
         CSR_LONG_MIN:   window_cfg.long_min_us   = data[15:0];
         CSR_LONG_MAX:   window_cfg.long_max_us   = data[15:0];
         CSR_EOF_MIN:    window_cfg.eof_min_us    = data[15:0];
         CSR_TIMER_WRAP: window_cfg.timer_wrap_us = data;
         default: ;
      endcase
   endtask

   // Upper half of a 16-bit register write is junk the block must ignore
   function automatic logic [31:0] with_junk(input logic [15:0] value);
      logic [31:0] junk;
      junk = $urandom;
      return {junk[31:16], value};
   endfunction

   task automatic load_windows(input cfg_type w);
      write_register(CSR_SOF_MIN,    with_junk(w.sof_min_us));
      write_register(CSR_SOF_MAX,    with_junk(w.sof_max_us));
      write_register(CSR_SHORT_MIN,  with_junk(w.short_min_us));
      write_register(CSR_SHORT_MAX,  with_junk(w.short_max_us));
      write_register(CSR_LONG_MIN,   with_junk(w.long_min_us));
      write_register(CSR_LONG_MAX,   with_junk(w.long_max_us));
      write_register(CSR_EOF_MIN,    with_junk(w.eof_min_us));
      write_register(CSR_TIMER_WRAP, w.timer_wrap_us);
      csr_valid <= 1'b0;
   endtask

   // Width inside a window, often on its bounds; anything for an inverted window
   function automatic logic [31:0] pick_width(input logic [15:0] lo, input logic [15:0] hi);
      if (lo > hi) return $urandom_range(400, 0);
      case ($urandom_range(3, 0))
         0:       return {16'h0, lo};
         1:       return {16'h0, hi};
         default: return $urandom_range({16'h0, hi}, {16'h0, lo});
      endcase
   endfunction

   // Start pulse, a run of symbols (sometimes past the buffer), then the closing pulse unless a resync breaks it off
   task automatic send_frame();
      int          nbits;
      int          n;
      logic [31:0] width;
      logic        level;
      width     = pick_width(window_cfg.sof_min_us, window_cfg.sof_max_us);
      cur_stamp = cur_stamp + width;
      send_request(CMD_EDGE, cur_stamp, LINE_LOW, 1'b0, 8'h00);
      nbits = ($urandom_range(5, 0) == 0) ? $urandom_range(104, 88) : $urandom_range(30, 0);
      for (n = 0; n < nbits; n++) begin
         level = 1'($urandom_range(1, 0));
         case ($urandom_range(4, 0))
            0: width = pick_width(window_cfg.short_min_us, window_cfg.short_max_us);
            1: width = pick_width(window_cfg.long_min_us, window_cfg.long_max_us);
            2: width = $urandom_range(400, 0);
            default: width = (level == LINE_HIGH) ?
                             pick_width(window_cfg.long_min_us, window_cfg.long_max_us) :
                             pick_width(window_cfg.short_min_us, window_cfg.short_max_us);
         endcase
         cur_stamp = cur_stamp + width;
         // now and then break the frame off with a resync
         if ($urandom_range(40, 0) == 0) begin
            send_request(CMD_RESYNC, cur_stamp, level, 1'b0, 8'h00);
            return;
         end
         send_request(CMD_EDGE, cur_stamp, level, 1'b0, 8'h00);
      end
      width     = {16'h0, window_cfg.eof_min_us} + $urandom_range(400, 1);
      cur_stamp = cur_stamp + width;
      send_request(CMD_EDGE, cur_stamp, LINE_HIGH, 1'b0, 8'h00);
   endtask

   // Resyncs anywhere, resyncs just below the timer wrap, stray edges, pauses
   task automatic send_noise();
      case ($urandom_range(3, 0))
         0: begin
            cur_stamp = $urandom;
            send_request(CMD_RESYNC, cur_stamp, 1'($urandom_range(1, 0)), 1'b0, 8'h00);
         end
         1: begin
            cur_stamp = 32'hFFFF_FFFF - $urandom_range(600, 0);
            send_request(CMD_RESYNC, cur_stamp, 1'($urandom_range(1, 0)), 1'b0, 8'h00);
         end
         2: begin
            repeat ($urandom_range(3, 1)) begin
               cur_stamp = $urandom;
               send_request(CMD_EDGE, cur_stamp, 1'($urandom_range(1, 0)), 1'b0, 8'h00);
            end
         end
         default: hold_until_drained();
      endcase
   endtask

   // Check each frame byte against the oldest one owed; stall on a rolling pattern
   always @(posedge clock) begin
      rx_byte_type want;
      logic [31:0] fresh;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               $error("frame byte with none owed: frame_byte %0h byte_index %0d",
                      rsp_frame_byte, rsp_byte_index);
               fail_count++;
            end else begin
               want = bytes_due.pop_front();
               checked_count++;
               if (rsp_frame_byte !== want.data) begin
                  $error("frame_byte: expected %0h, actual %0h", want.data, rsp_frame_byte);
                  fail_count++;
               end
               if (rsp_byte_index !== want.pos) begin
                  $error("byte_index: expected %0d, actual %0d", want.pos, rsp_byte_index);
                  fail_count++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte: expected %0b, actual %0b", want.last, rsp_last_byte);
                  fail_count++;
               end
            end
         end
         fresh = $urandom;
         if (pattern_step == 0) begin
            ready_pattern <= fresh[12:0];
            pattern_step  <= 12;
         end else begin
            ready_pattern <= ready_pattern >> 1;
            pattern_step  <= pattern_step - 1;
         end
         rsp_ready <= stall_free | ready_pattern[0];
      end
   end

   // Drop out if no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $error("no handshake for %0d cycles, %0d frame bytes still owed",
                WATCHDOG_LIMIT, bytes_due.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int row;
      int phase;
      cfg_type windows;
      reset_decoder();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table with the reset windows
      for (row = 0; row < DIRECTED_ROWS; row++)
         send_request(DIRECTED_EDGES[row].cmd, DIRECTED_EDGES[row].stamp,
                      DIRECTED_EDGES[row].level, DIRECTED_EDGES[row].typed,
                      DIRECTED_EDGES[row].byte0);
      cur_stamp = DIRECTED_EDGES[DIRECTED_ROWS-1].stamp;
      hold_until_drained();

      // random frames under a series of window settings
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            hold_until_drained();
            repeat (SETTLE_CYCLES) @(posedge clock);
            case (phase)
               1: windows = make_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF, 32'd1);
               2: windows = make_windows(16'd163, 16'd239, 16'd96, 16'd34, 16'd163, 16'd97,
                                         16'd0, 32'hFFFF_FFFF);
               3: begin
                  windows.sof_min_us    = 16'($urandom_range(300, 50));
                  windows.sof_max_us    = 16'(windows.sof_min_us + $urandom_range(80, 0));
                  windows.short_min_us  = 16'($urandom_range(60, 10));
                  windows.short_max_us  = 16'(windows.short_min_us + $urandom_range(60, 0));
                  windows.long_min_us   = 16'($urandom_range(160, 60));
                  windows.long_max_us   = 16'(windows.long_min_us + $urandom_range(80, 0));
                  windows.eof_min_us    = 16'($urandom_range(1000, 0));
                  windows.timer_wrap_us = $urandom_range(32'hFFFF_FFFF, 1);
               end
               default: windows = make_windows(16'd163, 16'd239, 16'd34, 16'd96, 16'd97,
                                               16'd163, 16'd239, 32'h8000_0000);
            endcase
            load_windows(windows);
         end
         idle_free  = (phase == 2);
         stall_free <= (phase == 2);
         frame_items = 0;
         while (frame_items < ITEMS_PER_PHASE) begin
            if ($urandom_range(4, 0) == 0)
               send_noise();
            else
               send_frame();
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d window settings; %0d frames, %0d frame bytes checked",
               sent_count, PHASES, frames_seen, checked_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> vpw_pulse_width_frame_receiver.f
rtl/vpw_pkg.sv
rtl/vpw_front.sv
rtl/vpw_event_queue.sv
rtl/vpw_back.sv
rtl/vpw_pulse_width_frame_receiver.sv
sim/vpw_pulse_width_frame_receiver_tb.sv
